FILE: rtl/core/spa_pkg.sv
// Package for the sparse polynomial adder: sizes, codes and shared types.
`default_nettype none
package spa_pkg;

   localparam int MaxTerms = 32;
   localparam int AddrW    = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
   localparam int CountW   = $clog2(MaxTerms + 1);
   localparam int CoeffW   = 32;
   localparam int ExpoW    = 16;
   localparam int SumW     = CoeffW + 1;
   localparam int TermW    = CoeffW + ExpoW;

   localparam logic [1:0] REQ_LOAD_A = 2'd0;
   localparam logic [1:0] REQ_LOAD_B = 2'd1;
   localparam logic [1:0] REQ_MERGE  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   typedef struct packed {
      logic signed [CoeffW-1:0] coeff;
      logic signed [ExpoW-1:0]  expo;
   } term_type;

   typedef struct packed {
      logic                   take_a;
      logic                   take_b;
      logic signed [SumW-1:0] coeff;
      logic signed [ExpoW-1:0] expo;
   } merge_res_type;

endpackage
`default_nettype wire

FILE: rtl/core/spa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spa_ram #(
   parameter int Width = 48,
   parameter int Depth = 32,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/core/spa_merge_unit.sv
// Shared compare and add unit: picks the next merged term from the two heads.
`default_nettype none
module spa_merge_unit
   import spa_pkg::*;
(
   input  wire term_type      a_term,
   input  wire term_type      b_term,
   input  wire logic          a_avail,
   input  wire logic          b_avail,
   output merge_res_type      res
);

   logic signed [SumW-1:0] a_ext;
   logic signed [SumW-1:0] b_ext;

   assign a_ext = {a_term.coeff[CoeffW-1], a_term.coeff};
   assign b_ext = {b_term.coeff[CoeffW-1], b_term.coeff};

   always_comb begin
      res.take_a = 1'b0;
      res.take_b = 1'b0;
      res.coeff  = b_ext;
      res.expo   = b_term.expo;
      priority if (a_avail && b_avail) begin
         if (a_term.expo > b_term.expo) begin
            res.take_a = 1'b1;
            res.coeff  = a_ext;
            res.expo   = a_term.expo;
         end else if (b_term.expo > a_term.expo) begin
            res.take_b = 1'b1;
         end else begin
            res.take_a = 1'b1;
            res.take_b = 1'b1;
            res.coeff  = a_ext + b_ext;
            res.expo   = a_term.expo;
         end
      end else if (a_avail) begin
         res.take_a = 1'b1;
         res.coeff  = a_ext;
         res.expo   = a_term.expo;
      end else begin
         res.take_b = b_avail;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/sparse_polynomial_add.sv
// Sparse polynomial adder: two term stores merged by exponent, one term out per cycle.
// A load item keeps busy low, so the next item can follow at once.
// A merge holds busy high in the merge state; its results pass the state register and
// then the output registers (store heads read one address ahead); new items wait for idle.
// An empty merge keeps busy low and answers in the next cycle; the receiver cannot stall.
// Synchronous active-high reset clears counts, pointers, overflow, valid and the sequencer.
`default_nettype none
module sparse_polynomial_add
   import spa_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [1:0]              req_type,
   input  wire logic signed [CoeffW-1:0] req_term_coeff,
   input  wire logic signed [ExpoW-1:0] req_term_expo,
   output logic                         rsp_valid,
   output logic signed [SumW-1:0]       rsp_sum_coeff,
   output logic signed [ExpoW-1:0]      rsp_sum_expo,
   output logic                         rsp_last_term,
   output logic                         rsp_no_terms,
   output logic                         rsp_load_dropped
);

   state_type            state_ff, state_in;
   logic [CountW-1:0]    count_a_ff, count_a_in;
   logic [CountW-1:0]    count_b_ff, count_b_in;
   logic [CountW-1:0]    ptr_a_ff, ptr_a_in;
   logic [CountW-1:0]    ptr_b_ff, ptr_b_in;
   logic                 overflow_ff, overflow_in;
   logic                 drop_ff, drop_in;
   logic                 valid_ff, valid_in;
   logic signed [SumW-1:0]  coeff_ff, coeff_in;
   logic signed [ExpoW-1:0] expo_ff, expo_in;
   logic                 last_ff, last_in;
   logic                 empty_ff, empty_in;

   logic                 accept;
   logic                 wr_a, wr_b;
   term_type             wr_term;
   logic [TermW-1:0]     rd_a_data, rd_b_data;
   term_type             head_a, head_b;
   logic                 a_avail, b_avail;
   merge_res_type        mres;

   assign accept  = start && (state_ff == ST_IDLE);
   assign wr_term = '{coeff: req_term_coeff, expo: req_term_expo};
   assign head_a  = term_type'(rd_a_data);
   assign head_b  = term_type'(rd_b_data);
   assign a_avail = ptr_a_ff < count_a_ff;
   assign b_avail = ptr_b_ff < count_b_ff;

   spa_ram #(.Width(TermW), .Depth(MaxTerms)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[AddrW-1:0]),
      .wr_data (wr_term),
      .rd_addr (ptr_a_in[AddrW-1:0]),
      .rd_data (rd_a_data)
   );

   spa_ram #(.Width(TermW), .Depth(MaxTerms)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[AddrW-1:0]),
      .wr_data (wr_term),
      .rd_addr (ptr_b_in[AddrW-1:0]),
      .rd_data (rd_b_data)
   );

   spa_merge_unit u_merge (
      .a_term  (head_a),
      .b_term  (head_b),
      .a_avail (a_avail),
      .b_avail (b_avail),
      .res     (mres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         ptr_a_ff    <= '0;
         ptr_b_ff    <= '0;
         overflow_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_a_ff  <= count_a_in;
         count_b_ff  <= count_b_in;
         ptr_a_ff    <= ptr_a_in;
         ptr_b_ff    <= ptr_b_in;
         overflow_ff <= overflow_in;
         valid_ff    <= valid_in;
      end
      drop_ff  <= drop_in;
      coeff_ff <= coeff_in;
      expo_ff  <= expo_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_a_in  = count_a_ff;
      count_b_in  = count_b_ff;
      ptr_a_in    = ptr_a_ff;
      ptr_b_in    = ptr_b_ff;
      overflow_in = overflow_ff;
      drop_in     = drop_ff;
      valid_in    = 1'b0;
      coeff_in    = coeff_ff;
      expo_in     = expo_ff;
      last_in     = last_ff;
      empty_in    = empty_ff;
      wr_a        = 1'b0;
      wr_b        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ptr_a_in = '0;
            ptr_b_in = '0;
            if (accept) begin
               unique case (req_type)
                  REQ_LOAD_A: begin
                     if (count_a_ff == CountW'(MaxTerms)) begin
                        overflow_in = 1'b1;
                     end else begin
                        wr_a       = 1'b1;
                        count_a_in = count_a_ff + CountW'(1);
                     end
                  end
                  REQ_LOAD_B: begin
                     if (count_b_ff == CountW'(MaxTerms)) begin
                        overflow_in = 1'b1;
                     end else begin
                        wr_b       = 1'b1;
                        count_b_in = count_b_ff + CountW'(1);
                     end
                  end
                  REQ_MERGE: begin
                     drop_in     = overflow_ff;
                     overflow_in = 1'b0;
                     if (count_a_ff == '0 && count_b_ff == '0) begin
                        valid_in = 1'b1;
                        coeff_in = '0;
                        expo_in  = '0;
                        last_in  = 1'b1;
                        empty_in = 1'b1;
                     end else begin
                        state_in = ST_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            ptr_a_in = ptr_a_ff + CountW'(mres.take_a);
            ptr_b_in = ptr_b_ff + CountW'(mres.take_b);
            valid_in = 1'b1;
            coeff_in = mres.coeff;
            expo_in  = mres.expo;
            empty_in = 1'b0;
            last_in  = (ptr_a_in >= count_a_ff) && (ptr_b_in >= count_b_ff);
            if (last_in) begin
               state_in   = ST_IDLE;
               count_a_in = '0;
               count_b_in = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_sum_coeff    = coeff_ff;
   assign rsp_sum_expo     = expo_ff;
   assign rsp_last_term    = last_ff;
   assign rsp_no_terms     = empty_ff;
   assign rsp_load_dropped = drop_ff;

`ifndef SYNTHESIS
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_terms |-> rsp_last_term)
      else $error("empty result without last mark");

   a_merge_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_last_term)
      else $error("merge ended without last result");

   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_term |=> rsp_valid)
      else $error("gap inside a result burst");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> ptr_a_ff <= count_a_ff && ptr_b_ff <= count_b_ff
         && (a_avail || b_avail))
      else $error("merge pointer past store count");
`endif

endmodule
`default_nettype wire
